/* rtl/occupancy_clear_holdoff_top_macros.svh */
// Assertion macros for the occupancy clear hold-off block
`ifndef OCCUPANCY_CLEAR_HOLDOFF_TOP_MACROS_SVH
`define OCCUPANCY_CLEAR_HOLDOFF_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define OCH_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define OCH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`define OCH_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define OCH_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define OCH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`define OCH_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/och_pkg.sv */
// Shared constants and types of the occupancy clear hold-off block
`timescale 1ns / 1ps
`default_nettype none

package och_pkg;

	localparam int ZONE_COUNT_DEF = 5;
	localparam int TICK_HZ_DEF    = 1000;

	localparam int NUM_HOLD   = 6;
	localparam int HOLD_W     = 16;
	localparam int TICKS_W    = 32;
	localparam int ZONE_W     = 5;
	localparam int COUNT_W    = 2;
	localparam int CH_W       = 3;
	localparam int VALUE_W    = 2;
	localparam int MAX_CH     = 1 << CH_W;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic {
		KIND_OCC   = 1'b0,
		KIND_COUNT = 1'b1
	} och_kind_t;

	typedef struct packed {
		logic               level;
		logic               pending;
		logic [TICKS_W-1:0] start;
	} och_chan_t;

	typedef struct packed {
		och_kind_t          kind;
		logic [CH_W-1:0]    channel;
		logic [VALUE_W-1:0] value;
	} och_rep_t;

endpackage

`default_nettype wire

/* rtl/och_if.sv */
// Poll and report channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface och_poll_if;
	logic                        valid;
	logic                        ready;
	logic                        joined;
	logic [och_pkg::TICKS_W-1:0] now_ticks;
	logic                        occupied_all;
	logic [och_pkg::ZONE_W-1:0]  zone_mask;
	logic [och_pkg::COUNT_W-1:0] target_count;

	modport source (output valid, joined, now_ticks, occupied_all, zone_mask, target_count,
		input ready);
	modport sink (input valid, joined, now_ticks, occupied_all, zone_mask, target_count,
		output ready);
endinterface

interface och_report_if;
	logic                        valid;
	logic                        ready;
	logic                        report_kind;
	logic [och_pkg::CH_W-1:0]    channel;
	logic [och_pkg::VALUE_W-1:0] value;
	logic                        last;

	modport source (output valid, report_kind, channel, value, last, input ready);
	modport sink (input valid, report_kind, channel, value, last, output ready);
endinterface

`default_nettype wire

/* rtl/occupancy_clear_holdoff_top.sv */
// The first report of a poll passes the issue stage, the compute stage and the held report
// register before it leaves the output register. A joined poll reads one channel of the state
// memory per cycle while the output does not stall, then takes the target count step; unjoined polls give no reports.
// Up to ZONE_COUNT + 2 reports per poll, one per cycle; output stalls hold the pipeline.
// Reset clears hold-off registers, channel state valid bits, count and all control state.
`timescale 1ns / 1ps
`default_nettype none
`include "occupancy_clear_holdoff_top_macros.svh"

module occupancy_clear_holdoff_top #(
	parameter int ZONE_COUNT = och_pkg::ZONE_COUNT_DEF,
	parameter int TICK_HZ    = och_pkg::TICK_HZ_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	och_poll_if.sink                           poll,
	och_report_if.source                       rpt,
	input  wire logic                          cfg_we,
	input  wire logic [och_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [och_pkg::HOLD_W-1:0]    cfg_data
);

	localparam int NCH    = ZONE_COUNT + 1;
	localparam int ST_W   = $clog2(NCH + 1);
	localparam int ADDR_W = $clog2(NCH);
	localparam int MAXC   = och_pkg::MAX_CH;
	localparam int CHW    = och_pkg::CH_W;
	localparam int TW     = och_pkg::TICKS_W;
	localparam int HW     = och_pkg::HOLD_W;
	localparam int VW     = och_pkg::VALUE_W;
	localparam int CW     = och_pkg::COUNT_W;
	localparam int ZW     = och_pkg::ZONE_W;

	// config
	logic [HW-1:0] hold_q [och_pkg::NUM_HOLD];

	// issue stage
	logic          s1_v_q;
	logic [ST_W-1:0] st_q;
	logic [TW-1:0] now_q;
	logic          occ_q;
	logic [ZW-1:0] mask_q;
	logic [CW-1:0] cnt_q;

	// compute stage
	logic          v_s2;
	logic [ST_W-1:0] st_s2;
	logic          cnt_step_s2;
	logic [TW-1:0] now_s2;
	logic          seen_s2;
	logic [TW-1:0] hold_ticks_s2;
	logic [CW-1:0] cnt_s2;
	och_pkg::och_chan_t rdata_s2;
	logic          rvld_s2;

	// state memory
	och_pkg::och_chan_t mem_q [NCH];
	logic [NCH-1:0] vld_q;
	logic [CW-1:0]  rcount_q;

	// report buffering
	logic              p_v_q;
	logic              p_last_q;
	och_pkg::och_rep_t p_q;
	logic              o_v_q;
	logic              o_last_q;
	och_pkg::och_rep_t o_q;

	logic              poll_xfer;
	logic              s1_last;
	logic              s1_adv;
	logic              adv;
	logic              step;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [CHW-1:0]    s1_sel;
	logic [MAXC-1:0]   seen_ext;
	logic [HW-1:0]     hold_ext [MAXC];
	logic [TW-1:0]     hold_ticks;
	och_pkg::och_chan_t cur;
	och_pkg::och_chan_t nxt;
	logic [TW-1:0]     elapsed;
	logic              rep_v;
	och_pkg::och_rep_t rep;
	logic              rep_step;
	logic              move;

	assign s1_last   = (st_q == ST_W'(NCH));
	assign adv       = !o_v_q || rpt.ready;
	assign s1_adv    = s1_v_q && (!v_s2 || adv);
	assign step      = v_s2 && adv;
	assign poll.ready = !s1_v_q || (s1_adv && s1_last);
	assign poll_xfer = poll.valid && poll.ready;

	assign rd_en   = s1_adv && !s1_last;
	assign rd_addr = st_q[ADDR_W-1:0];
	assign wr_en   = step && !cnt_step_s2;
	assign wr_addr = st_s2[ADDR_W-1:0];

	assign s1_sel   = CHW'(st_q);
	assign seen_ext = MAXC'({mask_q, occ_q});

	always_comb begin
		for (int i = 0; i < MAXC; i++) begin
			hold_ext[i] = '0;
		end
		for (int i = 0; i < och_pkg::NUM_HOLD; i++) begin
			hold_ext[i] = hold_q[i];
		end
		hold_ticks = TW'(hold_ext[s1_sel]) * TW'(TICK_HZ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < och_pkg::NUM_HOLD; i++) begin
				hold_q[i] <= '0;
			end
		end else if (cfg_we && (int'(cfg_index) < och_pkg::NUM_HOLD)) begin
			hold_q[cfg_index] <= cfg_data;
		end
	end

	// issue stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			st_q   <= '0;
		end else if (poll_xfer && poll.joined) begin
			s1_v_q <= 1'b1;
			st_q   <= '0;
		end else if (s1_adv && s1_last) begin
			s1_v_q <= 1'b0;
		end else if (s1_adv) begin
			st_q <= st_q + ST_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (poll_xfer) begin
			now_q  <= poll.now_ticks;
			occ_q  <= poll.occupied_all;
			mask_q <= poll.zone_mask;
			cnt_q  <= poll.target_count;
		end
	end

	// compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= 1'b1;
		end else if (step) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			st_s2         <= st_q;
			cnt_step_s2   <= s1_last;
			now_s2        <= now_q;
			seen_s2       <= seen_ext[s1_sel];
			hold_ticks_s2 <= hold_ticks;
			cnt_s2        <= cnt_q;
		end
	end

	// state memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= nxt;
		end
		if (rd_en) begin
			rdata_s2 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s2 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s2 <= vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		cur         = rvld_s2 ? rdata_s2 : '0;
		nxt         = cur;
		rep_v       = 1'b0;
		rep.kind    = och_pkg::KIND_OCC;
		rep.channel = CHW'(st_s2);
		rep.value   = '0;
		elapsed     = '0;
		if (cnt_step_s2) begin
			rep.kind    = och_pkg::KIND_COUNT;
			rep.channel = '0;
			rep.value   = VW'(cnt_s2);
			rep_v       = (cnt_s2 != rcount_q);
		end else begin
			if (seen_s2 && !cur.level) begin
				nxt.level   = 1'b1;
				nxt.pending = 1'b0;
				rep_v       = 1'b1;
				rep.value   = VW'(1);
			end else if (!seen_s2 && cur.level && !cur.pending) begin
				nxt.pending = 1'b1;
				nxt.start   = now_s2;
			end
			elapsed = now_s2 - nxt.start;
			if (nxt.pending && !seen_s2 && (elapsed >= hold_ticks_s2)) begin
				nxt.level   = 1'b0;
				nxt.pending = 1'b0;
				rep_v       = 1'b1;
				rep.value   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q <= '0;
		end else if (step && cnt_step_s2) begin
			rcount_q <= cnt_s2;
		end
	end

	// one report held back until the next one, or the end of the poll, fixes its last flag
	assign rep_step = step && rep_v;
	assign move     = p_v_q && (rep_step || p_last_q) && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_v_q    <= 1'b0;
			p_last_q <= 1'b0;
		end else if (rep_step) begin
			p_v_q    <= 1'b1;
			p_last_q <= cnt_step_s2;
		end else if (move) begin
			p_v_q <= 1'b0;
		end else if (step && cnt_step_s2 && p_v_q) begin
			p_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_step) begin
			p_q <= rep;
		end
		if (move) begin
			o_q      <= p_q;
			o_last_q <= p_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (move) begin
			o_v_q <= 1'b1;
		end else if (rpt.ready) begin
			o_v_q <= 1'b0;
		end
	end

	assign rpt.valid       = o_v_q;
	assign rpt.report_kind = o_q.kind;
	assign rpt.channel     = o_q.channel;
	assign rpt.value       = o_q.value;
	assign rpt.last        = o_last_q;

	`OCH_ASSERT_IMPL(a_rw_addr, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr, "read-write collision on state memory")
	`OCH_ASSERT_NEVER(a_orphan_rep, clk, arst_n, p_v_q && !p_last_q && !s1_v_q && !v_s2, "held report lost its last flag")
	`OCH_ASSERT_NEXT(a_count_last, clk, arst_n, step && cnt_step_s2 && rep_v, p_v_q && p_last_q && (p_q.kind == och_pkg::KIND_COUNT), "count report not final")
	`OCH_ASSERT_NEXT(a_poll_start, clk, arst_n, poll_xfer && poll.joined, s1_v_q && (st_q == '0), "joined poll did not start sweep")

endmodule

`default_nettype wire
